// ===== hw/rtl/dfpp_pkg.sv =====
// Shared types, register indexes, status codes and the power-of-ten table
// for the decimal fixed-point parser. No dependencies.
package dfpp_pkg;

    localparam int MAX_ARG_LEN_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_DIGITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BORROW_ENABLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_PART    = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_OK    = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [31:0] MAG_POS  = 32'h7FFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        unsigned_mode;
        logic [31:0] low_bound;
        logic [31:0] high_bound;
        logic [3:0]  fraction_digits;
        logic        borrow_enable;
        logic [63:0] integer_part;
    } cfg_t;

    // parser state at the end of an argument
    typedef struct packed {
        logic        has_num;
        logic        negative;
        logic        round_up;
        logic        overflowed;
        logic [31:0] accum;
        logic [3:0]  digits_left;
    } snap_t;

    // after zero padding
    typedef struct packed {
        logic        has_num;
        logic        negative;
        logic        round_up;
        logic        err;
        logic [61:0] product;
    } scaled_t;

    // 10^n for n up to 9; larger n never reaches a used result
    function automatic logic [29:0] pow_ten(input logic [3:0] n);
        logic [29:0] r;
        case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/dfpp_parse.sv =====
// Character front end: sign/digit state machine, accumulator, counters.
// Hands a snapshot of the state to the scale stage on the last item.
// Depends on dfpp_pkg.
module dfpp_parse #(
    parameter int MAX_ARG_LEN = dfpp_pkg::MAX_ARG_LEN_DEF,
    localparam int CNT_W = $clog2(MAX_ARG_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dfpp_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_ch,
    input  logic                s_last,
    output logic                snap_valid,
    output dfpp_pkg::snap_t     snap,
    output logic [CNT_W-1:0]    snap_count,
    input  logic                snap_ready
);
    import dfpp_pkg::*;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_ENDED  = 3'd3;
    localparam logic [2:0] PH_NONE   = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    logic [2:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic             round_reg, round_next;
    logic             ovf_reg, ovf_next;
    logic [31:0]      accum_reg, accum_next;
    logic [3:0]       dl_reg, dl_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;

    logic             snap_valid_reg;
    snap_t            snap_reg, snap_next;
    logic [CNT_W-1:0] snap_cnt_reg;

    logic        accept, is_digit, take, add_en;
    logic [3:0]  digit;
    logic [35:0] acc36, mul10, limit;

    assign s_ready    = !snap_valid_reg || snap_ready;
    assign accept     = s_valid && s_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
    assign snap_count = snap_cnt_reg;

    assign is_digit = (s_ch >= CH_ZERO) && (s_ch <= CH_NINE);
    assign digit    = s_ch[3:0];
    assign acc36    = {4'b0, accum_reg};
    assign mul10    = (acc36 << 3) + (acc36 << 1) + {32'b0, digit};
    assign limit    = (cfg.fraction_digits == 4'd0 && neg_reg) ? 36'h0_8000_0000
                                                               : 36'h0_7FFF_FFFF;
    assign cnt_inc  = (cnt_reg < CNT_W'(MAX_ARG_LEN)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        round_next = round_reg;
        ovf_next   = ovf_reg;
        accum_next = accum_reg;
        dl_next    = dl_reg;
        cnt_next   = cnt_reg;
        take       = 1'b0;
        add_en     = 1'b0;

        unique case (phase_reg)
            PH_START: begin
                if (!cfg.unsigned_mode && (s_ch == CH_MINUS || s_ch == CH_PLUS)) begin
                    neg_next   = (s_ch == CH_MINUS);
                    cnt_next   = cnt_inc;
                    phase_next = PH_SIGN;
                end else if (is_digit) begin
                    take = 1'b1;
                end else begin
                    phase_next = PH_NONE;
                end
            end
            PH_SIGN: begin
                if (is_digit) take = 1'b1;
                else          phase_next = PH_NONE;
            end
            PH_DIGITS: begin
                if (is_digit) take = 1'b1;
                else          phase_next = PH_ENDED;
            end
            default: ;
        endcase

        if (take) begin
            cnt_next = cnt_inc;
            if (phase_reg != PH_DIGITS) begin
                // first digit starts the number
                accum_next = {28'b0, digit};
                dl_next    = (cfg.fraction_digits != 4'd0) ? cfg.fraction_digits - 4'd1
                                                           : 4'd0;
                phase_next = PH_DIGITS;
            end else if (cfg.fraction_digits == 4'd0) begin
                add_en = 1'b1;
            end else if (dl_reg != 4'd0) begin
                add_en  = 1'b1;
                dl_next = dl_reg - 4'd1;
            end else if (digit != 4'd0) begin
                // excess nonzero digit: note it for rounding
                round_next = 1'b1;
            end
        end

        if (add_en && !ovf_reg) begin
            if (mul10 > limit) ovf_next = 1'b1;
            else               accum_next = mul10[31:0];
        end
    end

    always_comb begin
        snap_next.has_num     = (phase_next == PH_DIGITS) || (phase_next == PH_ENDED);
        snap_next.negative    = neg_next;
        snap_next.round_up    = round_next;
        snap_next.overflowed  = ovf_next;
        snap_next.accum       = accum_next;
        snap_next.digits_left = dl_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            neg_reg        <= 1'b0;
            round_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            accum_reg      <= 32'd0;
            dl_reg         <= 4'd0;
            cnt_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_last) begin
                    phase_reg <= PH_START;
                    neg_reg   <= 1'b0;
                    round_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                    accum_reg <= 32'd0;
                    dl_reg    <= 4'd0;
                    cnt_reg   <= '0;
                end else begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    round_reg <= round_next;
                    ovf_reg   <= ovf_next;
                    accum_reg <= accum_next;
                    dl_reg    <= dl_next;
                    cnt_reg   <= cnt_next;
                end
            end
            if (accept && s_last)  snap_valid_reg <= 1'b1;
            else if (snap_ready)   snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last) begin
            snap_reg     <= snap_next;
            snap_cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/dfpp_scale.sv =====
// Zero padding stage: multiplies the kept digits by 10^digits_left and
// collects the early error cases. Depends on dfpp_pkg.
module dfpp_scale #(
    parameter int MAX_ARG_LEN = dfpp_pkg::MAX_ARG_LEN_DEF,
    localparam int CNT_W = $clog2(MAX_ARG_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dfpp_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  dfpp_pkg::snap_t     in_snap,
    input  logic [CNT_W-1:0]    in_count,
    output logic                out_valid,
    output dfpp_pkg::scaled_t   out_data,
    output logic [CNT_W-1:0]    out_count,
    input  logic                out_ready
);
    import dfpp_pkg::*;

    logic             valid_reg;
    scaled_t          data_reg, data_next;
    logic [CNT_W-1:0] count_reg;
    logic             frac_mode;
    logic [3:0]       pad_idx;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_count = count_reg;

    assign frac_mode = (cfg.fraction_digits != 4'd0);
    assign pad_idx   = frac_mode ? in_snap.digits_left : 4'd0;

    always_comb begin
        data_next.has_num  = in_snap.has_num;
        data_next.negative = in_snap.negative;
        data_next.round_up = in_snap.round_up;
        data_next.err      = in_snap.overflowed
                          || (frac_mode && in_snap.negative && cfg.fraction_digits >= 4'd10)
                          || (frac_mode && in_snap.digits_left > 4'd9
                              && in_snap.accum != 32'd0);
        data_next.product  = {30'b0, in_snap.accum} * {32'b0, pow_ten(pad_idx)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg  <= data_next;
            count_reg <= in_count;
        end
    end

endmodule

// ===== hw/rtl/dfpp_finish.sv =====
// Result stage: sign, borrow form, range check and the output register.
// Depends on dfpp_pkg.
module dfpp_finish #(
    parameter int MAX_ARG_LEN = dfpp_pkg::MAX_ARG_LEN_DEF,
    localparam int CNT_W = $clog2(MAX_ARG_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dfpp_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  dfpp_pkg::scaled_t   in_data,
    input  logic [CNT_W-1:0]    in_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_parsed_value,
    output logic [CNT_W-1:0]    m_consumed,
    output logic signed [63:0]  m_integer_part_out,
    output logic                m_borrowed
);
    import dfpp_pkg::*;

    logic               valid_reg;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        value_reg, value_next;
    logic [CNT_W-1:0]   consumed_reg, consumed_next;
    logic [63:0]        ipart_reg, ipart_next;
    logic               borrowed_reg, borrowed_next;

    logic               frac_mode, prod_ovf, do_borrow, inc, range_bad, borrow_bad;
    logic               ok;
    logic [31:0]        mag;
    logic signed [33:0] v, min34, max34;

    assign in_ready = !valid_reg || m_ready;

    assign frac_mode = (cfg.fraction_digits != 4'd0);
    assign prod_ovf  = frac_mode && (|in_data.product[61:31]);
    assign mag       = in_data.product[31:0];
    assign do_borrow = frac_mode && in_data.negative && cfg.borrow_enable;
    assign inc       = in_data.round_up && (mag != MAG_POS);
    assign min34     = $signed({{2{cfg.low_bound[31]}}, cfg.low_bound});
    assign max34     = $signed({{2{cfg.high_bound[31]}}, cfg.high_bound});

    always_comb begin
        // borrow form: 10^frac - mag - round, one adder with carry-in
        if (do_borrow)
            v = $signed({4'b0, pow_ten(cfg.fraction_digits)}) - $signed({2'b0, mag})
                - $signed({33'b0, inc});
        else if (in_data.negative)
            v = -$signed({2'b0, mag});
        else
            v = $signed({2'b0, mag});
    end

    assign range_bad  = (v < min34) || (v > max34);
    assign borrow_bad = do_borrow && (cfg.integer_part == INT64_MIN);
    assign ok = in_data.has_num && !in_data.err && !prod_ovf && !range_bad && !borrow_bad;

    always_comb begin
        if (!in_data.has_num) status_next = STATUS_NONE;
        else if (!ok)         status_next = STATUS_RANGE;
        else                  status_next = STATUS_OK;
        value_next    = ok ? v[31:0] : 32'd0;
        consumed_next = ok ? in_count : '0;
        borrowed_next = ok && do_borrow;
        ipart_next    = (ok && do_borrow) ? cfg.integer_part - 64'd1 : cfg.integer_part;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            status_reg   <= status_next;
            value_reg    <= value_next;
            consumed_reg <= consumed_next;
            ipart_reg    <= ipart_next;
            borrowed_reg <= borrowed_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_status           = status_reg;
    assign m_parsed_value     = $signed(value_reg);
    assign m_consumed         = consumed_reg;
    assign m_integer_part_out = $signed(ipart_reg);
    assign m_borrowed         = borrowed_reg;

endmodule

// ===== hw/rtl/decimal_fixed_point_parser_core.sv =====
// Top level of the decimal fixed-point parser: configuration registers,
// parse / scale / finish stages. Depends on dfpp_pkg, dfpp_parse,
// dfpp_scale, dfpp_finish.
//
// Streams the characters of one argument, one item per cycle on s_* while
// s_ready is high, and parses its leading decimal number into a signed
// 32-bit value; the state of the argument lives in the parse stage. The
// item with s_last set closes the argument and produces one result on m_*,
// registered in turn in the parse stage's snapshot register, in the scale
// stage (the 32x30 multiply by 10^digits_left that pads missing fraction
// digits) and in the finish stage (sign or borrow form, min/max check,
// borrow from integer_part). All three stages hold an item each, so
// arguments may follow each other back to back, including one-character
// arguments, and input keeps flowing while a result waits at m_* until two
// more results are queued inside. Status 0 means no number, 1 a parsed
// value, 2 out of range or overflow; consumed counts sign and all digits,
// saturating at MAX_ARG_LEN, and is zero unless status is 1. Configuration
// registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while no argument is in flight, which the block
// itself does not enforce. An unknown index is ignored.
module decimal_fixed_point_parser_core #(
    parameter int MAX_ARG_LEN = dfpp_pkg::MAX_ARG_LEN_DEF,
    localparam int CNT_W = $clog2(MAX_ARG_LEN + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [dfpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dfpp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // character input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_ch,
    input  logic                               s_last,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic signed [31:0]                 m_parsed_value,
    output logic [CNT_W-1:0]                   m_consumed,
    output logic signed [63:0]                 m_integer_part_out,
    output logic                               m_borrowed
);
    import dfpp_pkg::*;

    cfg_t             cfg_reg;

    logic             snap_valid, snap_ready;
    snap_t            snap;
    logic [CNT_W-1:0] snap_count;

    logic             scl_valid, scl_ready;
    scaled_t          scl_data;
    logic [CNT_W-1:0] scl_count;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unsigned_mode   <= 1'b0;
            cfg_reg.low_bound       <= 32'h8000_0000;
            cfg_reg.high_bound      <= 32'h7FFF_FFFF;
            cfg_reg.fraction_digits <= 4'd0;
            cfg_reg.borrow_enable   <= 1'b0;
            cfg_reg.integer_part    <= 64'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_UNSIGNED_MODE:   cfg_reg.unsigned_mode   <= cfg_wdata[0];
                CFG_LOW_BOUND:       cfg_reg.low_bound       <= cfg_wdata[31:0];
                CFG_HIGH_BOUND:      cfg_reg.high_bound      <= cfg_wdata[31:0];
                CFG_FRACTION_DIGITS: cfg_reg.fraction_digits <= cfg_wdata[3:0];
                CFG_BORROW_ENABLE:   cfg_reg.borrow_enable   <= cfg_wdata[0];
                CFG_INTEGER_PART:    cfg_reg.integer_part    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dfpp_parse #(.MAX_ARG_LEN(MAX_ARG_LEN)) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .s_last     (s_last),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_count (snap_count),
        .snap_ready (snap_ready)
    );

    dfpp_scale #(.MAX_ARG_LEN(MAX_ARG_LEN)) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (snap_valid),
        .in_ready  (snap_ready),
        .in_snap   (snap),
        .in_count  (snap_count),
        .out_valid (scl_valid),
        .out_data  (scl_data),
        .out_count (scl_count),
        .out_ready (scl_ready)
    );

    dfpp_finish #(.MAX_ARG_LEN(MAX_ARG_LEN)) u_finish (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .in_valid           (scl_valid),
        .in_ready           (scl_ready),
        .in_data            (scl_data),
        .in_count           (scl_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_parsed_value     (m_parsed_value),
        .m_consumed         (m_consumed),
        .m_integer_part_out (m_integer_part_out),
        .m_borrowed         (m_borrowed)
    );

    // a failed or empty parse reports no value, count or borrow
    a_fail_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK
        |-> m_consumed == '0 && !m_borrowed && m_parsed_value == 32'sd0)
        else $error("non-ok result carries payload");

    // reported integer part is one below the register after a borrow
    a_borrow_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_borrowed
        |-> m_status == STATUS_OK && m_integer_part_out == cfg_reg.integer_part - 64'd1)
        else $error("borrow result inconsistent");

    // count saturates and status stays within its codes
    a_count_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_consumed <= CNT_W'(MAX_ARG_LEN)
                    && (m_status == STATUS_NONE || m_status == STATUS_OK
                        || m_status == STATUS_RANGE))
        else $error("consumed count or status out of range");

    // no result appears without an item in the scale stage the cycle before
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(scl_valid))
        else $error("result without source item");

endmodule

// ===== test/decimal_fixed_point_parser_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for decimal_fixed_point_parser_core: directed rows, then random
// arguments over many register settings, scored against a behavioral parser model.
// Depends on dfpp_pkg and the parser RTL only.

module decimal_fixed_point_parser_core_test;
    import dfpp_pkg::*;

    localparam int CNT_W           = 13;      // $clog2(MAX_ARG_LEN_DEF + 1)
    localparam int WATCHDOG_LIMIT  = 1000;    // cycles without any accepted item
    localparam int PHASE_COUNT     = 14;
    localparam int CALM_PHASES     = 3;       // final phases run with no idling
    localparam int ITEMS_PER_PHASE = 60;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [63:0] MAG_POS_LIMIT = 64'd2147483647;
    localparam logic [63:0] MAG_NEG_LIMIT = 64'd2147483648;
    localparam logic [63:0] INT64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef enum logic [2:0] {
        AWAIT_FIRST, SAW_SIGN, IN_DIGITS, PAST_NUMBER, NO_NUMBER
    } scan_phase_t;

    typedef struct {
        logic [1:0]        status;
        logic signed [31:0] value;
        logic [CNT_W-1:0]  consumed;
        logic signed [63:0] int_out;
        logic              borrowed;
    } parse_result_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct {
        char_item_t    item;
        bit            typed;   // 1: compare against want instead of the model
        parse_result_t want;
    } steer_row_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs known from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_ch      = '0;
    logic                  s_last    = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [1:0]            m_status;
    logic signed [31:0]    m_parsed_value;
    logic [CNT_W-1:0]      m_consumed;
    logic signed [63:0]    m_integer_part_out;
    logic                  m_borrowed;

    decimal_fixed_point_parser_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_ch               (s_ch),
        .s_last             (s_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_parsed_value     (m_parsed_value),
        .m_consumed         (m_consumed),
        .m_integer_part_out (m_integer_part_out),
        .m_borrowed         (m_borrowed)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model: register shadow plus per-argument scan state
    // ------------------------------------------------------------------
    cfg_t          shadow_cfg;
    scan_phase_t   scan_phase;
    logic          neg_sign;
    logic          round_flag;
    logic          ovf_flag;
    logic [63:0]   mag_acc;
    logic [3:0]    frac_left;
    int            char_cnt;
    parse_result_t results_due[$];   // predicted results, oldest first

    // run bookkeeping
    bit         calm = 1'b0;         // no idling on either side
    int         failures = 0;
    int         chars_sent = 0;
    int         args_sent = 0;
    int         reg_writes = 0;
    int         results_seen = 0;
    int         ok_seen = 0;
    int         range_seen = 0;
    int         borrow_seen = 0;
    int         quiet_cycles = 0;
    char_item_t arg_chars[$];
    steer_row_t steer_rows[$];

    function automatic logic [63:0] ten_pow(input int n);
        logic [63:0] r;
        r = 64'd1;
        repeat (n) r = r * 64'd10;
        return r;
    endfunction

    function automatic void clear_scan();
        scan_phase = AWAIT_FIRST;
        neg_sign   = 1'b0;
        round_flag = 1'b0;
        ovf_flag   = 1'b0;
        mag_acc    = '0;
        frac_left  = '0;
        char_cnt   = 0;
    endfunction

    function automatic void bump_count();
        if (char_cnt < MAX_ARG_LEN_DEF) char_cnt++;
    endfunction

    // accumulate one digit; the first digit that would pass the limit sticks overflow
    function automatic void push_digit(input logic [63:0] d, input logic [63:0] limit);
        logic [63:0] m;
        if (ovf_flag) return;
        m = mag_acc * 64'd10 + d;
        if (m > limit) ovf_flag = 1'b1;
        else mag_acc = m;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [3:0]  fd;
        d  = 64'(c - CH_ZERO);
        fd = shadow_cfg.fraction_digits;
        bump_count();
        if (scan_phase != IN_DIGITS) begin
            mag_acc    = d;
            frac_left  = (fd != 0) ? fd - 4'd1 : 4'd0;
            scan_phase = IN_DIGITS;
        end else if (fd == 0) begin
            push_digit(d, neg_sign ? MAG_NEG_LIMIT : MAG_POS_LIMIT);
        end else if (frac_left != 0) begin
            push_digit(d, MAG_POS_LIMIT);
            frac_left--;
        end else if (d != 0) begin
            // excess fraction digit: only remembered for rounding
            round_flag = 1'b1;
        end
    endfunction

    function automatic parse_result_t close_argument();
        parse_result_t r;
        logic [63:0]   mag;
        longint        v;
        bit            borrow;
        logic [3:0]    fd;
        fd     = shadow_cfg.fraction_digits;
        borrow = 1'b0;
        r = '{STATUS_NONE, 32'sd0, '0, shadow_cfg.integer_part, 1'b0};
        if (scan_phase != IN_DIGITS && scan_phase != PAST_NUMBER) return r;
        r.status = STATUS_RANGE;
        if (ovf_flag) return r;
        if (fd == 0) begin
            v = neg_sign ? -longint'(mag_acc) : longint'(mag_acc);
        end else begin
            // scale 10^fd no longer fits 32 bits for a negative fraction
            if (neg_sign && fd >= 10) return r;
            mag = mag_acc;
            if (frac_left != 0 && mag != 0) begin
                if (frac_left > 9) return r;
                mag = mag * ten_pow(frac_left);
                if (mag > MAG_POS_LIMIT) return r;
            end
            if (neg_sign && shadow_cfg.borrow_enable) begin
                // floor rounding, then complement against 10^fd
                if (round_flag && mag < MAG_POS_LIMIT) mag++;
                v      = longint'(ten_pow(fd)) - longint'(mag);
                borrow = 1'b1;
            end else begin
                v = neg_sign ? -longint'(mag) : longint'(mag);
            end
        end
        if (v < longint'($signed(shadow_cfg.low_bound)) ||
            v > longint'($signed(shadow_cfg.high_bound))) return r;
        if (borrow) begin
            if (shadow_cfg.integer_part == INT64_MIN) return r;
            r.int_out  = shadow_cfg.integer_part - 64'd1;
            r.borrowed = 1'b1;
        end
        r.status   = STATUS_OK;
        r.value    = v[31:0];
        r.consumed = char_cnt[CNT_W-1:0];
        return r;
    endfunction

    // advance the model by one accepted item; returns 1 when a result is due
    function automatic bit scan_char(input char_item_t it, output parse_result_t r);
        bit is_digit;
        is_digit = (it.ch >= CH_ZERO) && (it.ch <= CH_NINE);
        r = '{STATUS_NONE, 32'sd0, '0, 64'sd0, 1'b0};
        case (scan_phase)
            AWAIT_FIRST: begin
                if (!shadow_cfg.unsigned_mode && (it.ch == CH_MINUS || it.ch == CH_PLUS)) begin
                    neg_sign = (it.ch == CH_MINUS);
                    bump_count();
                    scan_phase = SAW_SIGN;
                end else if (is_digit) begin
                    take_digit(it.ch);
                end else begin
                    scan_phase = NO_NUMBER;
                end
            end
            SAW_SIGN: begin
                if (is_digit) take_digit(it.ch);
                else scan_phase = NO_NUMBER;
            end
            IN_DIGITS: begin
                if (is_digit) take_digit(it.ch);
                else scan_phase = PAST_NUMBER;
            end
            default: ;
        endcase
        if (!it.last) return 1'b0;
        r = close_argument();
        clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one item, hold it until accepted, then feed the model.
    // Idle bursts lower valid first; otherwise valid stays high back to back.
    task automatic send_char(input char_item_t it, input bit typed, input parse_result_t want);
        parse_result_t predicted;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= it.ch;
        s_last  <= it.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        if (scan_char(it, predicted)) results_due.push_back(typed ? want : predicted);
    endtask

    // Drop valid, let every predicted result drain out of the three stages,
    // then keep idling so the pipeline is empty before writes.
    task automatic settle();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        reg_writes++;
        case (idx)
            CFG_UNSIGNED_MODE:   shadow_cfg.unsigned_mode   = data[0];
            CFG_LOW_BOUND:       shadow_cfg.low_bound       = data[31:0];
            CFG_HIGH_BOUND:      shadow_cfg.high_bound      = data[31:0];
            CFG_FRACTION_DIGITS: shadow_cfg.fraction_digits = data[3:0];
            CFG_BORROW_ENABLE:   shadow_cfg.borrow_enable   = data[0];
            CFG_INTEGER_PART:    shadow_cfg.integer_part    = data;
            default: ;
        endcase
    endtask

    // Write all six registers; unused upper data bits carry junk on purpose.
    task automatic apply_setting(input logic um, input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [3:0] fd, input logic be, input logic [63:0] ip);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_UNSIGNED_MODE, {junk[63:1], um});
        write_reg(CFG_LOW_BOUND, {junk[63:32], lo});
        write_reg(CFG_HIGH_BOUND, {junk[31:0], hi});
        write_reg(CFG_FRACTION_DIGITS, {junk[63:4], fd});
        write_reg(CFG_BORROW_ENABLE, {junk[62:0], be});
        write_reg(CFG_INTEGER_PART, ip);
        if ($urandom_range(0, 1) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3:       return $urandom;
            4:       return 32'($urandom_range(0, 200000)) - 32'd100000;
            default: return 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    function automatic logic [63:0] pick_int_part();
        case ($urandom_range(0, 4))
            0:       return INT64_MIN;
            1:       return INT64_MAX;
            2:       return 64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] pick_non_digit();
        logic [7:0] c;
        c = 8'($urandom_range(0, 245));
        if (c >= CH_ZERO) c = c + 8'd10;
        return c;
    endfunction

    function automatic void add_char(input logic [7:0] c);
        char_item_t it;
        it.ch   = c;
        it.last = 1'b0;
        arg_chars.push_back(it);
    endfunction

    function automatic void add_text(input string text, input bit typed, input parse_result_t want);
        steer_row_t row;
        foreach (text[i]) begin
            row.item.ch   = text[i];
            row.item.last = (i == text.len() - 1);
            row.typed     = typed && row.item.last;
            row.want      = want;
            steer_rows.push_back(row);
        end
    endfunction

    // Mostly well-formed numbers with random content, plus boundary values
    // around 2^31, noise, broken signs and one-character arguments.
    task automatic build_argument();
        int          n;
        int          kind;
        string       digits_text;
        logic [63:0] near_limit;
        arg_chars.delete();
        kind = $urandom_range(0, 15);
        if (kind <= 9) begin
            if ($urandom_range(0, 2) == 0) add_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            case ($urandom_range(0, 7))
                0, 1, 2, 3: n = $urandom_range(1, 4);
                4, 5:       n = $urandom_range(5, 9);
                6:          n = $urandom_range(10, 11);
                default:    n = $urandom_range(12, 18);
            endcase
            repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) begin
                // trailing text after the number is ignored
                add_char(pick_non_digit());
                repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 255)));
            end
        end else if (kind <= 11) begin
            near_limit = 64'd2147483646 + 64'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) add_char(CH_MINUS);
            digits_text = $sformatf("%0d", near_limit);
            foreach (digits_text[i]) add_char(digits_text[i]);
        end else if (kind <= 13) begin
            repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)));
        end else if (kind == 14) begin
            // sign followed by something that is not a digit
            add_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            add_char($urandom_range(0, 1) ? ($urandom_range(0, 1) ? CH_MINUS : CH_PLUS)
                                          : pick_non_digit());
            repeat ($urandom_range(0, 3)) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            case ($urandom_range(0, 2))
                0:       add_char(CH_ZERO + 8'($urandom_range(0, 9)));
                1:       add_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                default: add_char(8'($urandom_range(0, 255)));
            endcase
        end
        arg_chars[arg_chars.size() - 1].last = 1'b1;
    endtask

    task automatic send_argument();
        parse_result_t unused;
        unused = '{STATUS_NONE, 32'sd0, '0, 64'sd0, 1'b0};
        foreach (arg_chars[i]) send_char(arg_chars[i], 1'b0, unused);
        args_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure bursts, none in calm phases
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: status %0d value %0d consumed %0d",
                             m_status, m_parsed_value, m_consumed);
            end else begin
                want = results_due.pop_front();
                if (m_status !== want.status || m_parsed_value !== want.value ||
                    m_consumed !== want.consumed || m_integer_part_out !== want.int_out ||
                    m_borrowed !== want.borrowed) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display({"result %0d mismatch: expected status %0d value %0d ",
                                  "consumed %0d ipart %0d borrowed %0d, got %0d %0d %0d %0d %0d"},
                                 results_seen, want.status, want.value, want.consumed,
                                 want.int_out, want.borrowed, m_status, m_parsed_value,
                                 m_consumed, m_integer_part_out, m_borrowed);
                end
            end
            if (m_status === STATUS_OK) ok_seen++;
            if (m_status === STATUS_RANGE) range_seen++;
            if (m_borrowed === 1'b1) borrow_seen++;
        end
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without progress", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] swap;
        logic [3:0]  fd;
        int          items;
        parse_result_t none_res;
        parse_result_t range_res;

        // model state after reset
        shadow_cfg = '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0, 1'b0, 64'd0};
        clear_scan();

        // directed rows under reset defaults; fixed expectations where obvious
        none_res  = '{STATUS_NONE, 32'sd0, '0, 64'sd0, 1'b0};
        range_res = '{STATUS_RANGE, 32'sd0, '0, 64'sd0, 1'b0};
        add_text("x", 1'b1, none_res);                 // no number at all
        add_text("-", 1'b1, none_res);                 // sign without digits
        add_text("-2147483648", 1'b1,
                 '{STATUS_OK, 32'sh8000_0000, 13'd11, 64'sd0, 1'b0});
        add_text("2147483648", 1'b1, range_res);       // one past the positive limit
        add_text("0", 1'b1, '{STATUS_OK, 32'sd0, 13'd1, 64'sd0, 1'b0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (steer_rows[i]) send_char(steer_rows[i].item, steer_rows[i].typed,
                                          steer_rows[i].want);
        args_sent += 5;
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            calm = (p >= PHASE_COUNT - CALM_PHASES);
            case (p)
                // digits only, non-negative range
                0: apply_setting(1'b1, 32'd0, 32'h7FFF_FFFF, 4'd0, 1'b0, pick_int_part());
                // borrow from the most negative integer part
                1: apply_setting(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 4'd3, 1'b1, INT64_MIN);
                // widest fraction: negative values cannot be scaled
                2: apply_setting(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15, 1'b1, INT64_MAX);
                3: apply_setting(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 4'd9, 1'b1,
                                 pick_int_part());
                4: apply_setting(1'b0, 32'(-50), 32'd50, 4'd1, 1'b0, pick_int_part());
                default: begin
                    lo = pick_bound();
                    hi = pick_bound();
                    if ($signed(lo) > $signed(hi) && $urandom_range(0, 7) != 0) begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                    case ($urandom_range(0, 3))
                        0:       fd = 4'd0;
                        1, 2:    fd = 4'($urandom_range(1, 9));
                        default: fd = 4'($urandom_range(10, 15));
                    endcase
                    apply_setting($urandom_range(0, 3) == 0, lo, hi, fd,
                                  $urandom_range(0, 1), pick_int_part());
                end
            endcase

            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                build_argument();
                items += arg_chars.size();
                send_argument();
            end
            settle();
        end

        failures += results_due.size();

        $display("sent %0d characters in %0d arguments across %0d settings (%0d reg writes)",
                 chars_sent, args_sent, PHASE_COUNT + 1, reg_writes);
        $display("checked %0d results: %0d parsed, %0d out of range, %0d with borrow",
                 results_seen, ok_seen, range_seen, borrow_seen);
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", failures);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
